// ===== rtl/text_console_cursor_scroll_defines.svh =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_defines: assertion macros for the console block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg: shared constants and types of the text console.
// Store size, field widths, character codes and the geometry record.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int SCREEN_CELLS = 4096;
    localparam int CELL_W       = $clog2(SCREEN_CELLS);
    localparam int CNT_W        = $clog2(SCREEN_CELLS + 1);

    localparam int ROW_W  = 6;
    localparam int COL_W  = 8;
    localparam int CHAR_W = 8;
    localparam int RIDX_W = 12;
    localparam int POS_W  = 12;

    localparam int PROD_W = ROW_W + COL_W;
    localparam int GEO_W  = (PROD_W > CNT_W) ? PROD_W : CNT_W;
    localparam int CMP_W  = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [ROW_W-1:0]  ROW_RESET    = 6'd25;
    localparam logic [COL_W-1:0]  COL_RESET    = 8'd80;
    localparam logic [CHAR_W-1:0] ATTR_DEFAULT = 8'h07;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

    typedef enum logic {
        CMD_PUT  = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic {
        CFG_ROW_COUNT = 1'b0,
        CFG_COL_COUNT = 1'b1
    } t_cfg_idx;

    // Effective screen geometry: columns and visible cell count.
    typedef struct packed {
        logic [COL_W-1:0] cols;
        logic [CNT_W-1:0] cells;
    } t_geom;

endpackage

// ===== rtl/tcc_ram.sv =====
// ----------------------------------------------------------------------------
// tcc_ram: generic simple dual-port RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcc_geom.sv =====
// ----------------------------------------------------------------------------
// tcc_geom: effective screen geometry unit.
// Multiplies rows by columns once, then subtracts a row per cycle until the
// visible area fits in the store.
// ----------------------------------------------------------------------------
module tcc_geom (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tcc_pkg::ROW_W-1:0]  i_row_count,
    input  logic [tcc_pkg::COL_W-1:0]  i_col_count,
    output logic                       o_done,
    output tcc_pkg::t_geom             o_geom
);

    logic                      r_busy;
    logic                      r_mul;
    logic                      r_done;
    logic [tcc_pkg::ROW_W-1:0] r_rows;
    logic [tcc_pkg::COL_W-1:0] r_cols;
    logic [tcc_pkg::GEO_W-1:0] r_acc;

    logic [tcc_pkg::ROW_W-1:0] w_rows_in;
    logic [tcc_pkg::COL_W-1:0] w_cols_in;

    always_comb begin
        w_rows_in = (i_row_count == '0) ? tcc_pkg::ROW_W'(1) : i_row_count;
        priority if (i_col_count == '0) begin
            w_cols_in = tcc_pkg::COL_W'(1);
        end else if (tcc_pkg::GEO_W'(i_col_count) > tcc_pkg::GEO_W'(tcc_pkg::SCREEN_CELLS)) begin
            w_cols_in = tcc_pkg::COL_W'(tcc_pkg::SCREEN_CELLS);
        end else begin
            w_cols_in = i_col_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mul  <= 1'b1;
            end else if (r_busy && r_mul) begin
                r_mul <= 1'b0;
            end else if (r_busy) begin
                if (r_acc <= tcc_pkg::GEO_W'(tcc_pkg::SCREEN_CELLS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rows <= w_rows_in;
            r_cols <= w_cols_in;
        end else if (r_busy && r_mul) begin
            r_acc <= tcc_pkg::GEO_W'(tcc_pkg::PROD_W'(r_rows) * tcc_pkg::PROD_W'(r_cols));
        end else if (r_busy && (r_acc > tcc_pkg::GEO_W'(tcc_pkg::SCREEN_CELLS))) begin
            // Drop one row; the result is the row count clamped so the visible area fits the store.
            r_acc <= r_acc - tcc_pkg::GEO_W'(r_cols);
        end
    end

    assign o_done       = r_done;
    assign o_geom.cols  = r_cols;
    assign o_geom.cells = r_acc[tcc_pkg::CNT_W-1:0];

endmodule

// ===== rtl/tcc_rem.sv =====
// ----------------------------------------------------------------------------
// tcc_rem: iterative remainder unit.
// Restoring division, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module tcc_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tcc_pkg::CELL_W-1:0]  i_dividend,
    input  logic [tcc_pkg::COL_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [tcc_pkg::COL_W-1:0]   o_rem
);

    localparam int STEP_W = $clog2(tcc_pkg::CELL_W + 1);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_cnt;
    logic [tcc_pkg::CELL_W-1:0] r_dvd;
    logic [tcc_pkg::COL_W-1:0]  r_div;
    logic [tcc_pkg::COL_W-1:0]  r_rem;

    logic [tcc_pkg::COL_W:0]    w_trial;
    logic [tcc_pkg::COL_W:0]    w_diff;
    logic [tcc_pkg::COL_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[tcc_pkg::CELL_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        // The partial remainder stays below the divisor, so eight bits hold it.
        n_rem   = (w_trial >= {1'b0, r_div}) ? w_diff[tcc_pkg::COL_W-1:0]
                                             : w_trial[tcc_pkg::COL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(tcc_pkg::CELL_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[tcc_pkg::CELL_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll: text console with cursor, scroll and cell read.
// A read passes S_READ and a plain put S_PUT before S_DONE emits the result word;
// a newline also waits in S_DIV for the remainder unit, a changed geometry once in S_GEOM.
// A scroll rewrites every visible cell, one cell per cycle on the write port.
// Synchronous reset, then a clearing pass over all SCREEN_CELLS (4096) cells.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_defines.svh"

module text_console_cursor_scroll (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input word: [0] cmd, [8:1] char_code, [20:9] read_index.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tcc_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // Result word: [11:0] cursor_pos, [19:12] read_char, [27:20] read_attr,
    // [28] scrolled.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tcc_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [tcc_pkg::COL_W-1:0]     i_cfg_wdata
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_GEOM   = 9'b000000100,
        S_PUT    = 9'b000001000,
        S_READ   = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_SCROLL = 9'b001000000,
        S_DRAIN  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    localparam int PAD_W = tcc_pkg::M_DATA_W - tcc_pkg::POS_W - 2 * tcc_pkg::CHAR_W - 1;

    t_state                       r_state, n_state;
    logic [tcc_pkg::CELL_W-1:0]   r_clr_addr, n_clr_addr;
    logic [tcc_pkg::CELL_W-1:0]   r_cursor, n_cursor;
    logic                         r_scrolled, n_scrolled;
    logic [tcc_pkg::CELL_W-1:0]   r_nl_c, n_nl_c;
    logic [tcc_pkg::CELL_W-1:0]   r_scr_idx, n_scr_idx;
    tcc_pkg::t_cmd                r_cmd, n_cmd;
    logic [tcc_pkg::CHAR_W-1:0]   r_ch, n_ch;
    logic                         r_ridx_oob, n_ridx_oob;
    logic [tcc_pkg::CHAR_W-1:0]   r_rd_char, n_rd_char;
    logic [tcc_pkg::CHAR_W-1:0]   r_rd_attr, n_rd_attr;
    logic                         r_out_vld, n_out_vld;
    logic [tcc_pkg::M_DATA_W-1:0] r_out_data, n_out_data;
    logic                         r_geo_dirty, n_geo_dirty;
    logic [tcc_pkg::ROW_W-1:0]    r_row_count, n_row_count;
    logic [tcc_pkg::COL_W-1:0]    r_col_count, n_col_count;
    logic                         r_wr_vld, n_wr_vld;
    logic [tcc_pkg::CELL_W-1:0]   r_wr_addr, n_wr_addr;
    logic                         r_wr_copy, n_wr_copy;

    logic                         s_accept;
    tcc_pkg::t_cmd                in_cmd;
    logic [tcc_pkg::CHAR_W-1:0]   in_ch;
    logic [tcc_pkg::RIDX_W-1:0]   in_ridx;
    logic [tcc_pkg::CMP_W-1:0]    w_ridx_ext;

    tcc_pkg::t_geom               w_geo;
    logic                         w_geo_start;
    logic                         w_geo_done;
    logic                         w_rem_start;
    logic                         w_rem_done;
    logic [tcc_pkg::COL_W-1:0]    w_rem;

    logic [tcc_pkg::CNT_W-1:0]    w_cells_m1;
    logic [tcc_pkg::CELL_W-1:0]   w_last;
    logic [tcc_pkg::CNT_W-1:0]    w_keep;
    logic [tcc_pkg::CELL_W-1:0]   w_cur;
    logic [tcc_pkg::CNT_W-1:0]    w_nl_sum;
    logic                         w_nl_wrap;
    logic [tcc_pkg::CELL_W-1:0]   w_nl_c;
    logic [tcc_pkg::CNT_W-1:0]    w_scr_src;
    logic [tcc_pkg::CMP_W-1:0]    w_pos_ext;

    logic                         w_we_char;
    logic                         w_we_attr;
    logic [tcc_pkg::CELL_W-1:0]   w_waddr;
    logic [tcc_pkg::CHAR_W-1:0]   w_char_wdata;
    logic [tcc_pkg::CHAR_W-1:0]   w_attr_wdata;
    logic [tcc_pkg::CELL_W-1:0]   w_raddr;
    logic [tcc_pkg::CHAR_W-1:0]   w_char_rdata;
    logic [tcc_pkg::CHAR_W-1:0]   w_attr_rdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = tcc_pkg::t_cmd'(s_axis_tdata[0]);
    assign in_ch         = s_axis_tdata[8:1];
    assign in_ridx       = s_axis_tdata[20:9];
    assign w_ridx_ext    = tcc_pkg::CMP_W'(in_ridx);

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    assign w_geo_start = s_accept && (in_cmd == tcc_pkg::CMD_PUT) && r_geo_dirty;
    assign w_rem_start = (r_state == S_PUT) && (r_ch == tcc_pkg::CH_NEWLINE);

    tcc_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_geo_start),
        .i_row_count (r_row_count),
        .i_col_count (r_col_count),
        .o_done      (w_geo_done),
        .o_geom      (w_geo)
    );

    tcc_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_nl_c),
        .i_divisor  (w_geo.cols),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    // Cursor arithmetic on the current geometry.
    always_comb begin
        w_cells_m1 = w_geo.cells - tcc_pkg::CNT_W'(1);
        w_last     = w_cells_m1[tcc_pkg::CELL_W-1:0];
        w_keep     = w_geo.cells - tcc_pkg::CNT_W'(w_geo.cols);
        // A cursor left beyond a shrunken screen is pulled to the last cell.
        w_cur      = (tcc_pkg::CNT_W'(r_cursor) >= w_geo.cells) ? w_last : r_cursor;
        w_nl_sum   = tcc_pkg::CNT_W'(w_cur) + tcc_pkg::CNT_W'(w_geo.cols);
        w_nl_wrap  = (w_nl_sum >= w_geo.cells);
        w_nl_c     = w_nl_wrap ? w_cur : w_nl_sum[tcc_pkg::CELL_W-1:0];
        w_scr_src  = tcc_pkg::CNT_W'(r_scr_idx) + tcc_pkg::CNT_W'(w_geo.cols);
        w_pos_ext  = tcc_pkg::CMP_W'(r_cursor);
    end

    // Store port selection.
    always_comb begin
        w_we_char    = 1'b0;
        w_we_attr    = 1'b0;
        w_waddr      = r_wr_addr;
        w_char_wdata = r_wr_copy ? w_char_rdata : '0;
        w_attr_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_we_char    = 1'b1;
            w_we_attr    = 1'b1;
            w_waddr      = r_clr_addr;
            w_char_wdata = '0;
        end else if ((r_state == S_PUT) && (r_ch != tcc_pkg::CH_NEWLINE) &&
                     (r_ch != tcc_pkg::CH_BACKSPACE) && (r_ch != tcc_pkg::CH_RETURN)) begin
            w_we_char    = 1'b1;
            w_we_attr    = 1'b1;
            w_waddr      = w_cur;
            w_char_wdata = r_ch;
            w_attr_wdata = tcc_pkg::ATTR_DEFAULT;
        end else if (r_wr_vld) begin
            w_we_char = 1'b1;
        end
        w_raddr = (r_state == S_SCROLL) ? w_scr_src[tcc_pkg::CELL_W-1:0]
                                        : w_ridx_ext[tcc_pkg::CELL_W-1:0];
    end

    tcc_ram #(
        .WIDTH (tcc_pkg::CHAR_W),
        .DEPTH (tcc_pkg::SCREEN_CELLS)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_char),
        .i_waddr (w_waddr),
        .i_wdata (w_char_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_char_rdata)
    );

    tcc_ram #(
        .WIDTH (tcc_pkg::CHAR_W),
        .DEPTH (tcc_pkg::SCREEN_CELLS)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_attr),
        .i_waddr (w_waddr),
        .i_wdata (w_attr_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_attr_rdata)
    );

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cursor    = r_cursor;
        n_scrolled  = r_scrolled;
        n_nl_c      = r_nl_c;
        n_scr_idx   = r_scr_idx;
        n_cmd       = r_cmd;
        n_ch        = r_ch;
        n_ridx_oob  = r_ridx_oob;
        n_rd_char   = r_rd_char;
        n_rd_attr   = r_rd_attr;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_out_data  = r_out_data;
        n_geo_dirty = r_geo_dirty;
        n_row_count = r_row_count;
        n_col_count = r_col_count;
        n_wr_vld    = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_wr_copy   = r_wr_copy;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + tcc_pkg::CELL_W'(1);
                if (r_clr_addr == tcc_pkg::CELL_W'(tcc_pkg::SCREEN_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_cmd      = in_cmd;
                    n_ch       = in_ch;
                    n_ridx_oob = (w_ridx_ext >= tcc_pkg::CMP_W'(tcc_pkg::SCREEN_CELLS));
                    n_scrolled = 1'b0;
                    n_rd_char  = '0;
                    n_rd_attr  = '0;
                    priority if (in_cmd == tcc_pkg::CMD_READ) begin
                        n_state = S_READ;
                    end else if (r_geo_dirty) begin
                        n_state = S_GEOM;
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end
            S_GEOM: begin
                if (w_geo_done) begin
                    n_geo_dirty = 1'b0;
                    n_state     = S_PUT;
                end
            end
            S_READ: begin
                n_rd_char = r_ridx_oob ? '0 : w_char_rdata;
                n_rd_attr = r_ridx_oob ? '0 : w_attr_rdata;
                n_state   = S_DONE;
            end
            S_PUT: begin
                n_scr_idx = '0;
                unique case (r_ch)
                    tcc_pkg::CH_NEWLINE: begin
                        n_nl_c     = w_nl_c;
                        n_scrolled = w_nl_wrap;
                        n_state    = S_DIV;
                    end
                    tcc_pkg::CH_BACKSPACE: begin
                        n_cursor = (w_cur == '0) ? '0 : w_cur - tcc_pkg::CELL_W'(1);
                        n_state  = S_DONE;
                    end
                    tcc_pkg::CH_RETURN: begin
                        n_cursor = w_cur;
                        n_state  = S_DONE;
                    end
                    default: begin
                        if (w_cur == w_last) begin
                            n_cursor   = w_keep[tcc_pkg::CELL_W-1:0];
                            n_scrolled = 1'b1;
                            n_state    = S_SCROLL;
                        end else begin
                            n_cursor = w_cur + tcc_pkg::CELL_W'(1);
                            n_state  = S_DONE;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (w_rem_done) begin
                    // Start of the row that holds the new position.
                    n_cursor = r_nl_c - tcc_pkg::CELL_W'(w_rem);
                    n_state  = r_scrolled ? S_SCROLL : S_DONE;
                end
            end
            S_SCROLL: begin
                // Read the cell one row below; its word, or zero in the last row, is written back in the next cycle.
                n_wr_vld  = 1'b1;
                n_wr_addr = r_scr_idx;
                n_wr_copy = (tcc_pkg::CNT_W'(r_scr_idx) < w_keep);
                if (tcc_pkg::CNT_W'(r_scr_idx) == w_cells_m1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_scr_idx = r_scr_idx + tcc_pkg::CELL_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {{PAD_W{1'b0}}, r_scrolled, r_rd_attr, r_rd_char,
                                  w_pos_ext[tcc_pkg::POS_W-1:0]};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_geo_dirty = 1'b1;
            unique case (tcc_pkg::t_cfg_idx'(i_cfg_idx))
                tcc_pkg::CFG_ROW_COUNT: n_row_count = i_cfg_wdata[tcc_pkg::ROW_W-1:0];
                tcc_pkg::CFG_COL_COUNT: n_col_count = i_cfg_wdata;
                default:                n_geo_dirty = r_geo_dirty;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cursor    <= '0;
            r_out_vld   <= 1'b0;
            r_geo_dirty <= 1'b1;
            r_row_count <= tcc_pkg::ROW_RESET;
            r_col_count <= tcc_pkg::COL_RESET;
            r_wr_vld    <= 1'b0;
            r_scrolled  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cursor    <= n_cursor;
            r_out_vld   <= n_out_vld;
            r_geo_dirty <= n_geo_dirty;
            r_row_count <= n_row_count;
            r_col_count <= n_col_count;
            r_wr_vld    <= n_wr_vld;
            r_scrolled  <= n_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nl_c     <= n_nl_c;
        r_scr_idx  <= n_scr_idx;
        r_cmd      <= n_cmd;
        r_ch       <= n_ch;
        r_ridx_oob <= n_ridx_oob;
        r_rd_char  <= n_rd_char;
        r_rd_attr  <= n_rd_attr;
        r_out_data <= n_out_data;
        r_wr_addr  <= n_wr_addr;
        r_wr_copy  <= n_wr_copy;
    end

    `TCC_ASSERT_IMP(a_put_cursor_visible,
        (r_state == S_DONE) && (r_cmd == tcc_pkg::CMD_PUT),
        tcc_pkg::CNT_W'(r_cursor) < w_geo.cells,
        "cursor outside the visible screen after a put")
    `TCC_ASSERT_IMP(a_scroll_write_visible,
        r_wr_vld,
        tcc_pkg::CNT_W'(r_wr_addr) < w_geo.cells,
        "scroll write beyond the visible screen")
    `TCC_ASSERT_IMP(a_put_geometry_clean,
        r_state == S_PUT,
        !r_geo_dirty,
        "put handled with stale geometry")
    `TCC_ASSERT_IMP(a_rem_done_in_div,
        w_rem_done,
        r_state == S_DIV,
        "remainder result arrived outside the newline wait")
    `TCC_ASSERT_NXT(a_scroll_last_drains,
        (r_state == S_SCROLL) && (tcc_pkg::CNT_W'(r_scr_idx) == w_cells_m1),
        r_wr_vld && (r_state == S_DRAIN),
        "last scroll cell not written back")

endmodule

// ===== tb/text_console_cursor_scroll_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb: self-checking bench for the text console.
// A scoreboard keeps its own cursor, character store, attribute store and
// geometry, predicts every result word and checks it field by field. The
// bench walks through a series of screen geometries with random character
// streams, reads and random stalls on both stream ports, switched off for one geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_scroll_tb;

    import tcc_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 8;
    // Longest scroll walks the full store, so settling waits cover one.
    localparam int          SETTLE_CYCLES = SCREEN_CELLS + 64;
    localparam int unsigned CYCLE_LIMIT   = 5_000_000;
    localparam int          MAX_REPORTS   = 10;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CHAR_W-1:0] read_char;
        logic [CHAR_W-1:0] read_attr;
        logic              scrolled;
    } console_result_t;

    class console_scoreboard;
        bit [CHAR_W-1:0]   glyphs [SCREEN_CELLS];
        bit [CHAR_W-1:0]   attrs [SCREEN_CELLS];
        int unsigned       cursor;
        bit [ROW_W-1:0]    row_reg;
        bit [COL_W-1:0]    col_reg;
        console_result_t   expected_q [$];
        int unsigned       errors;
        int unsigned       accepted;
        int unsigned       checked;
        int unsigned       reads;
        int unsigned       scrolls;

        function new();
            foreach (glyphs[i]) begin
                glyphs[i] = '0;
                attrs[i]  = '0;
            end
            cursor   = 0;
            row_reg  = ROW_RESET;
            col_reg  = COL_RESET;
            errors   = 0;
            accepted = 0;
            checked  = 0;
            reads    = 0;
            scrolls  = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, bit [COL_W-1:0] value);
            if (idx == CFG_ROW_COUNT)
                row_reg = value[ROW_W-1:0];
            else
                col_reg = value;
        endfunction

        // Zero counts as one; rows are cut so the screen fits the store.
        function void geometry(output int unsigned cols, output int unsigned rows);
            cols = (col_reg == 0) ? 1 : col_reg;
            if (cols > SCREEN_CELLS)
                cols = SCREEN_CELLS;
            rows = (row_reg == 0) ? 1 : row_reg;
            if (rows > SCREEN_CELLS / cols)
                rows = SCREEN_CELLS / cols;
        endfunction

        function int unsigned visible_cells();
            int unsigned cols, rows;
            geometry(cols, rows);
            return rows * cols;
        endfunction

        // Characters move up one row; attributes are left where they are.
        function void shift_up(int unsigned rows, int unsigned cols);
            int unsigned keep;
            keep = (rows - 1) * cols;
            for (int unsigned i = 0; i < rows * cols; i++)
                glyphs[i] = (i < keep) ? glyphs[i + cols] : '0;
            scrolls++;
        endfunction

        function void note_input(t_cmd cmd, bit [CHAR_W-1:0] ch, bit [RIDX_W-1:0] ridx);
            console_result_t want;
            int unsigned     cols, rows, cells, nxt;
            want = '0;
            accepted++;
            if (cmd == CMD_READ) begin
                reads++;
                if (ridx < SCREEN_CELLS) begin
                    want.read_char = glyphs[ridx];
                    want.read_attr = attrs[ridx];
                end
            end else begin
                geometry(cols, rows);
                cells = rows * cols;
                if (cursor >= cells)
                    cursor = cells - 1;
                if (ch == CH_NEWLINE) begin
                    nxt = cursor + cols;
                    if (nxt >= cells) begin
                        shift_up(rows, cols);
                        want.scrolled = 1'b1;
                        nxt -= cols;
                    end
                    cursor = (nxt / cols) * cols;
                end else if (ch == CH_BACKSPACE) begin
                    if (cursor > 0)
                        cursor--;
                end else if (ch != CH_RETURN) begin
                    glyphs[cursor] = ch;
                    attrs[cursor]  = ATTR_DEFAULT;
                    if (cursor == cells - 1) begin
                        shift_up(rows, cols);
                        want.scrolled = 1'b1;
                        cursor = cells - cols;
                    end else begin
                        cursor++;
                    end
                end
            end
            want.cursor_pos = cursor[POS_W-1:0];
            expected_q.push_back(want);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] word);
            console_result_t got, want;
            got.cursor_pos = word[11:0];
            got.read_char  = word[19:12];
            got.read_attr  = word[27:20];
            got.scrolled   = word[28];
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: result word %h arrived with nothing expected", word);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.cursor_pos !== want.cursor_pos || got.read_char !== want.read_char ||
                got.read_attr !== want.read_attr || got.scrolled !== want.scrolled) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("ERROR: result %0d expected cursor %h char %h attr %h scrolled %b",
                             checked, want.cursor_pos, want.read_char, want.read_attr,
                             want.scrolled);
                    $display("       actual cursor %h char %h attr %h scrolled %b",
                             got.cursor_pos, got.read_char, got.read_attr, got.scrolled);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_idx     = 1'b0;
    logic [COL_W-1:0]     i_cfg_wdata   = '0;

    console_scoreboard    sb;
    bit                   idle_on       = 1'b1;
    int unsigned          cycle_count   = 0;
    int unsigned          geom_count    = 1;

    text_console_cursor_scroll dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= !idle_on || ($urandom_range(99) >= 12);

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic push_word(t_cmd cmd, bit [CHAR_W-1:0] ch, bit [RIDX_W-1:0] ridx);
        while (idle_on && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ridx, ch, cmd};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        sb.note_input(cmd, ch, ridx);
        @(negedge i_clk);
    endtask

    task automatic put_char(bit [CHAR_W-1:0] ch);
        push_word(CMD_PUT, ch, RIDX_W'($urandom_range(4095)));
    endtask

    task automatic read_cell(bit [RIDX_W-1:0] ridx);
        push_word(CMD_READ, CHAR_W'($urandom_range(255)), ridx);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, bit [COL_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        @(negedge i_clk);
    endtask

    task automatic set_geometry(bit [COL_W-1:0] rows, bit [COL_W-1:0] cols);
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_write(CFG_ROW_COUNT, rows);
        cfg_write(CFG_COL_COUNT, cols);
        i_cfg_we <= 1'b0;
        geom_count++;
    endtask

    // Mostly random bytes with control characters and reads mixed in.
    task automatic run_phase(int unsigned count, int unsigned newline_pct);
        int unsigned pick;
        for (int unsigned k = 0; k < count; k++) begin
            if (k == count / 2)
                wait_drain();
            pick = $urandom_range(99);
            if (pick < 10) begin
                if ($urandom_range(1))
                    read_cell(RIDX_W'($urandom_range(4095)));
                else
                    read_cell(RIDX_W'($urandom_range(sb.visible_cells() - 1)));
            end else begin
                pick = $urandom_range(99);
                if (pick < newline_pct)
                    put_char(CH_NEWLINE);
                else if (pick < newline_pct + 5)
                    put_char(CH_BACKSPACE);
                else if (pick < newline_pct + 8)
                    put_char(CH_RETURN);
                else
                    put_char(CHAR_W'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default geometry: extreme bytes, ignored return, backspace held at zero.
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_RETURN);
        repeat (4) put_char(CH_BACKSPACE);
        read_cell(12'd0);
        read_cell(12'd1);
        read_cell(12'd2);
        read_cell(12'd4095);
        read_cell(12'd79);
        put_char(CH_NEWLINE);
        put_char(8'h7F);
        read_cell(12'd80);
        run_phase(150, 15);

        // Single cell: the cursor sits beyond the screen until a put pulls it in.
        set_geometry(8'd1, 8'd1);
        read_cell(12'd5);
        put_char(8'h78);
        read_cell(12'd0);
        put_char(CH_NEWLINE);
        run_phase(60, 15);

        set_geometry(8'd0, 8'd0);
        run_phase(40, 15);

        idle_on = 1'b0;
        set_geometry(8'd3, 8'd5);
        run_phase(130, 10);
        idle_on = 1'b1;

        set_geometry(8'd32, 8'd128);
        run_phase(100, 10);

        // Rows beyond what fits the store are cut back.
        set_geometry(8'hFF, 8'd255);
        run_phase(100, 10);

        set_geometry(8'hC2, 8'd128);
        run_phase(150, 15);

        set_geometry(8'd32, 8'd1);
        run_phase(150, 10);

        set_geometry(8'd1, 8'd128);
        run_phase(150, 10);

        set_geometry(8'd25, 8'd80);
        run_phase(100, 15);

        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Checked %0d of %0d words over %0d geometries: %0d reads, %0d scrolls.",
                 sb.checked, sb.accepted, geom_count, sb.reads, sb.scrolls);
        $display("Mismatches: %0d, results still outstanding: %0d", sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== text_console_cursor_scroll.f =====
+incdir+rtl
rtl/tcc_pkg.sv
rtl/tcc_ram.sv
rtl/tcc_geom.sv
rtl/tcc_rem.sv
rtl/text_console_cursor_scroll.sv
tb/text_console_cursor_scroll_tb.sv
